>>> sv/euler_rotation_3d_core_defines.svh
// Assertion macros used by the checker file.
`ifndef EULER_ROTATION_3D_CORE_DEFINES_SVH
`define EULER_ROTATION_3D_CORE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define ER3_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define ER3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> sv/er3d_pkg.sv
`default_nettype none
package er3d_pkg;
   localparam int ANGLE_BITS   = 19;
   localparam int CORDIC_STEPS = 18;
   localparam int CW           = 34;  // CORDIC x/y width, Q2.30 plus guard
   localparam int ZW           = 28;  // CORDIC residual angle, Q3.24
   localparam int TW           = 18;  // trig value, Q1.16 in [-65536, 65536]
   localparam int MW           = 19;  // matrix entry, sums of two trig products

   localparam logic signed [ANGLE_BITS+1:0] PI_Q16      = 21'sd205887;
   localparam logic signed [ANGLE_BITS+1:0] TWO_PI_Q16  = 21'sd411775;
   localparam logic signed [ANGLE_BITS+1:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   typedef logic signed [TW-1:0] trig_type;
   typedef logic signed [MW-1:0] mat_type;

   // One CORDIC lane: residual angle, x, y and the fold flag.
   typedef struct packed {
      logic signed [ZW-1:0] z;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 neg;
   } cordic_type;

   function automatic logic signed [ZW-1:0] atan_q24(input int i);
      logic signed [ZW-1:0] v;
      unique case (i)
         0: v = 28'sd13176795;
         1: v = 28'sd7778716;
         2: v = 28'sd4110060;
         3: v = 28'sd2086331;
         4: v = 28'sd1047214;
         5: v = 28'sd524117;
         6: v = 28'sd262123;
         7: v = 28'sd131069;
         default: v = ZW'(28'sd65536 >>> (i - 8));
      endcase
      return v;
   endfunction

   // Product of two Q1.16 values, rounded to nearest (halves up).
   function automatic trig_type mul16(input logic signed [MW-1:0] a,
                                      input logic signed [MW-1:0] b);
      logic signed [2*MW-1:0] p;
      p = a * b + (2*MW)'(32768);
      return TW'(p >>> 16);
   endfunction
endpackage
`default_nettype wire

>>> sv/er3d_sincos.sv
`default_nettype none
// Pipelined sine/cosine: angle wrap and fold, one CORDIC step per stage,
// then rounding. Advances when en is high.
module er3d_sincos (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic signed [er3d_pkg::ANGLE_BITS-1:0] angle,
   output er3d_pkg::trig_type                          sin_out,
   output er3d_pkg::trig_type                          cos_out
);
   import er3d_pkg::*;

   cordic_type stage_ff [CORDIC_STEPS+1];
   cordic_type stage_in [CORDIC_STEPS+1];
   trig_type   sin_ff, cos_ff;
   trig_type   sin_in, cos_in;

   logic signed [ANGLE_BITS+1:0] wrap_a, fold_a;
   logic                         fold_neg;

   always_comb begin
      wrap_a = (ANGLE_BITS+2)'(angle);
      if (wrap_a > PI_Q16) begin
         wrap_a = wrap_a - TWO_PI_Q16;
      end else if (wrap_a < -PI_Q16) begin
         wrap_a = wrap_a + TWO_PI_Q16;
      end
      fold_a   = wrap_a;
      fold_neg = 1'b0;
      if (wrap_a > HALF_PI_Q16) begin
         fold_a   = wrap_a - PI_Q16;
         fold_neg = 1'b1;
      end else if (wrap_a < -HALF_PI_Q16) begin
         fold_a   = wrap_a + PI_Q16;
         fold_neg = 1'b1;
      end
      stage_in[0].z   = ZW'(fold_a) <<< 8;
      stage_in[0].x   = CORDIC_GAIN_Q30;
      stage_in[0].y   = '0;
      stage_in[0].neg = fold_neg;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_comb begin
         stage_in[i+1].neg = stage_ff[i].neg;
         if (stage_ff[i].z >= 0) begin
            stage_in[i+1].x = stage_ff[i].x - (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y + (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z - atan_q24(i);
         end else begin
            stage_in[i+1].x = stage_ff[i].x + (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y - (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z + atan_q24(i);
         end
      end
   end

   function automatic trig_type round_clamp(input logic signed [CW-1:0] v,
                                            input logic neg);
      logic signed [CW-1:0] r;
      trig_type             t;
      r = (v + CW'(8192)) >>> 14;
      if (r > CW'(65536)) begin
         t = TW'(65536);
      end else if (r < -CW'(65536)) begin
         t = -TW'(65536);
      end else begin
         t = TW'(r);
      end
      return neg ? -t : t;
   endfunction

   always_comb begin
      sin_in = round_clamp(stage_ff[CORDIC_STEPS].y, stage_ff[CORDIC_STEPS].neg);
      cos_in = round_clamp(stage_ff[CORDIC_STEPS].x, stage_ff[CORDIC_STEPS].neg);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;
endmodule
`default_nettype wire

>>> sv/euler_rotation_3d_core.sv
`default_nettype none
// Z-Y-X Euler rotation of one 3-D point per transfer.
// Input channel (req_): a signed point pos_x/y/z in Q11.12 and yaw, pitch
// and roll angles in Q2.16 radians. Any 19-bit angle is wrapped by 2*pi.
// Result channel (rsp_): the rotated point rot_x/y/z in Q11.12, saturated.
// The block is a single pipeline of 25 register stages: angle fold and 18
// CORDIC steps in one stage each, trig rounding, two stages of matrix
// products, the matrix sums, the coordinate products and the final sum with
// rounding and saturation. Throughput is one point per cycle while the
// receiver does not stall; the CORDIC stage count sets only the latency,
// not the rate.
// A valid bit travels with each stage. The whole pipeline advances when
// the output stage is empty or being taken, so a stalled receiver freezes
// every stage and nothing is lost or repeated. req_ready follows that
// advance condition.
// Reset clears all valid bits; data registers are not reset.
module euler_rotation_3d_core #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [COORD_BITS-1:0]           req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]           req_pos_y,
   input  wire logic signed [COORD_BITS-1:0]           req_pos_z,
   input  wire logic signed [er3d_pkg::ANGLE_BITS-1:0] req_yaw_angle,
   input  wire logic signed [er3d_pkg::ANGLE_BITS-1:0] req_pitch_angle,
   input  wire logic signed [er3d_pkg::ANGLE_BITS-1:0] req_roll_angle,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [COORD_BITS-1:0]                rsp_rot_x,
   output logic signed [COORD_BITS-1:0]                rsp_rot_y,
   output logic signed [COORD_BITS-1:0]                rsp_rot_z
);
   import er3d_pkg::*;

   // Trig results are registered after the fold, CORDIC step and rounding stages.
   localparam int TRIG_LAT = CORDIC_STEPS + 2;
   localparam int DEPTH    = TRIG_LAT + 5;
   localparam int PW       = MW + COORD_BITS;   // entry times coordinate
   localparam int SW       = PW + 2;            // sum of three products

   logic                  en;
   logic [DEPTH-1:0]      valid_ff, valid_in;

   assign en        = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = en;

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // Point delay line; the tap PT lines up with the matrix entries.
   logic signed [COORD_BITS-1:0] px_ff [DEPTH-2];
   logic signed [COORD_BITS-1:0] py_ff [DEPTH-2];
   logic signed [COORD_BITS-1:0] pz_ff [DEPTH-2];

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff[0] <= req_pos_x;
         py_ff[0] <= req_pos_y;
         pz_ff[0] <= req_pos_z;
         for (int k = 1; k < DEPTH-2; k++) begin
            px_ff[k] <= px_ff[k-1];
            py_ff[k] <= py_ff[k-1];
            pz_ff[k] <= pz_ff[k-1];
         end
      end
   end

   trig_type sa, ca, sb, cb, sg, cg;

   er3d_sincos u_yaw (.clock(clock), .en(en), .angle(req_yaw_angle),
                      .sin_out(sa), .cos_out(ca));
   er3d_sincos u_pitch (.clock(clock), .en(en), .angle(req_pitch_angle),
                        .sin_out(sb), .cos_out(cb));
   er3d_sincos u_roll (.clock(clock), .en(en), .angle(req_roll_angle),
                       .sin_out(sg), .cos_out(cg));

   // Stage A: two-factor products.
   trig_type a_cacb_ff, a_casb_ff, a_sacg_ff, a_sasg_ff, a_sacb_ff, a_sasb_ff;
   trig_type a_cacg_ff, a_casg_ff, a_cbsg_ff, a_cbcg_ff;
   trig_type a_sb_ff, a_sg_ff, a_cg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_cacb_ff <= mul16(MW'(ca), MW'(cb));
         a_casb_ff <= mul16(MW'(ca), MW'(sb));
         a_sacg_ff <= mul16(MW'(sa), MW'(cg));
         a_sasg_ff <= mul16(MW'(sa), MW'(sg));
         a_sacb_ff <= mul16(MW'(sa), MW'(cb));
         a_sasb_ff <= mul16(MW'(sa), MW'(sb));
         a_cacg_ff <= mul16(MW'(ca), MW'(cg));
         a_casg_ff <= mul16(MW'(ca), MW'(sg));
         a_cbsg_ff <= mul16(MW'(cb), MW'(sg));
         a_cbcg_ff <= mul16(MW'(cb), MW'(cg));
         a_sb_ff   <= sb;
         a_sg_ff   <= sg;
         a_cg_ff   <= cg;
      end
   end

   // Stage B: triple products.
   trig_type b_t1sg_ff, b_t1cg_ff, b_t2sg_ff, b_t2cg_ff;
   trig_type b_cacb_ff, b_sacg_ff, b_sasg_ff, b_sacb_ff, b_cacg_ff, b_casg_ff;
   trig_type b_cbsg_ff, b_cbcg_ff, b_sb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         b_t1sg_ff <= mul16(MW'(a_casb_ff), MW'(a_sg_ff));
         b_t1cg_ff <= mul16(MW'(a_casb_ff), MW'(a_cg_ff));
         b_t2sg_ff <= mul16(MW'(a_sasb_ff), MW'(a_sg_ff));
         b_t2cg_ff <= mul16(MW'(a_sasb_ff), MW'(a_cg_ff));
         b_cacb_ff <= a_cacb_ff;
         b_sacg_ff <= a_sacg_ff;
         b_sasg_ff <= a_sasg_ff;
         b_sacb_ff <= a_sacb_ff;
         b_cacg_ff <= a_cacg_ff;
         b_casg_ff <= a_casg_ff;
         b_cbsg_ff <= a_cbsg_ff;
         b_cbcg_ff <= a_cbcg_ff;
         b_sb_ff   <= a_sb_ff;
      end
   end

   // Stage C: matrix entries.
   mat_type m_ff [3][3];

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0][0] <= MW'(b_cacb_ff);
         m_ff[0][1] <= MW'(b_t1sg_ff) - MW'(b_sacg_ff);
         m_ff[0][2] <= MW'(b_t1cg_ff) + MW'(b_sasg_ff);
         m_ff[1][0] <= MW'(b_sacb_ff);
         m_ff[1][1] <= MW'(b_t2sg_ff) + MW'(b_cacg_ff);
         m_ff[1][2] <= MW'(b_t2cg_ff) - MW'(b_casg_ff);
         m_ff[2][0] <= -MW'(b_sb_ff);
         m_ff[2][1] <= MW'(b_cbsg_ff);
         m_ff[2][2] <= MW'(b_cbcg_ff);
      end
   end

   // Stage D: entry times coordinate products.
   logic signed [PW-1:0] prod_ff [3][3];
   localparam int PT = DEPTH - 3;   // point delay tap aligned to stage D

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= PW'(m_ff[r][0]) * PW'(px_ff[PT]);
            prod_ff[r][1] <= PW'(m_ff[r][1]) * PW'(py_ff[PT]);
            prod_ff[r][2] <= PW'(m_ff[r][2]) * PW'(pz_ff[PT]);
         end
      end
   end

   // Stage E: sum, round and saturate.
   logic signed [COORD_BITS-1:0] out_ff [3];
   logic signed [COORD_BITS-1:0] out_in [3];
   logic signed [SW-1:0]         acc [3];
   localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_BITS-1)) - 1);
   localparam logic signed [SW-1:0] LO = -HI - SW'(1);

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = (SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2])
                   + SW'(32768)) >>> 16;
         if (acc[r] > HI) begin
            out_in[r] = COORD_BITS'(HI);
         end else if (acc[r] < LO) begin
            out_in[r] = COORD_BITS'(LO);
         end else begin
            out_in[r] = COORD_BITS'(acc[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            out_ff[r] <= out_in[r];
         end
      end
   end

   assign rsp_valid = valid_ff[DEPTH-1];
   assign rsp_rot_x = out_ff[0];
   assign rsp_rot_y = out_ff[1];
   assign rsp_rot_z = out_ff[2];
endmodule
`default_nettype wire

>>> sv/er3d_checker.sv
`default_nettype none
`include "euler_rotation_3d_core_defines.svh"
// Port-level checks of the rotation core.
module er3d_checker #(
   parameter int COORD_BITS = 24
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] rsp_rot_x
);
   // A stalled result keeps its valid and value.
   `ER3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_rot_x))
   // The input is ready whenever the output side is empty.
   `ER3_ASSERT_IMPL(a_ready_empty, clock, reset, !rsp_valid, req_ready)
   // A stall at the output blocks the input.
   `ER3_ASSERT_IMPL(a_ready_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)
endmodule

bind euler_rotation_3d_core er3d_checker #(.COORD_BITS(COORD_BITS)) u_er3d_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_rot_x(rsp_rot_x)
);
`default_nettype wire
